### src/c3mf_pkg.sv
// shared types and constants for the 3x3 multi-filter convolution block
package c3mf_pkg;

  localparam int TAPS       = 9;
  localparam int REQ_W      = 2;
  localparam int PIX_W      = 8;
  localparam int FILT_W     = 3;
  localparam int TAP_W      = 4;
  localparam int WGT_W      = 16;
  localparam int BIAS_W     = 28;
  localparam int ACC_W      = 29;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 5;
  localparam int VAL_W      = 28;
  localparam int FSEL_W     = 4;
  localparam int CFGW_W     = 6;
  localparam int CFGH_W     = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFGW_W-1:0] WIDTH_RST  = CFGW_W'(28);
  localparam logic [CFGH_W-1:0] HEIGHT_RST = CFGH_W'(28);

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL  = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_BIAS   = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  // one entry of the tap chain: a filter pass over a window or a weight write
  typedef struct packed {
    logic                          valid;
    logic                          is_wr;
    logic [FSEL_W-1:0]             filt;
    logic [TAP_W-1:0]              tap;
    logic signed [WGT_W-1:0]       wval;
    logic [TAPS-1:0][PIX_W-1:0]    pix;
    logic signed [ACC_W-1:0]       psum;
    logic [ROW_W-1:0]              row;
    logic [COL_W-1:0]              col;
    logic                          last;
  } tok_t;

endpackage

### src/c3mf_ifs.sv
// valid/ready channel interfaces for requests and results
interface c3mf_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [c3mf_pkg::REQ_W-1:0]                req_type;
  logic [c3mf_pkg::PIX_W-1:0]                pixel;
  logic [c3mf_pkg::FILT_W-1:0]               filter_index;
  logic [c3mf_pkg::TAP_W-1:0]                tap_index;
  logic signed [c3mf_pkg::WGT_W-1:0]         weight_value;
  logic signed [c3mf_pkg::BIAS_W-1:0]        bias_value;

  modport source (
    output valid, req_type, pixel, filter_index, tap_index, weight_value, bias_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, pixel, filter_index, tap_index, weight_value, bias_value,
    output ready
  );
endinterface

interface c3mf_out_if;
  logic                          valid;
  logic                          ready;
  logic [c3mf_pkg::FILT_W-1:0]   channel;
  logic [c3mf_pkg::ROW_W-1:0]    out_row;
  logic [c3mf_pkg::COL_W-1:0]    out_col;
  logic [c3mf_pkg::VAL_W-1:0]    value;
  logic                          last;

  modport source (
    output valid, channel, out_row, out_col, value, last,
    input  ready
  );
  modport sink (
    input  valid, channel, out_row, out_col, value, last,
    output ready
  );
endinterface

### src/conv3x3_multi_filter_relu_top.sv
// top level of the streaming 3x3 multi-filter convolution with relu
//
//  channel  dir  payload                                             beat
//  req      in   req_type pixel filter_index tap_index weight bias   one request
//  res      out  channel out_row out_col value last                  one filter result
//  cfg      in   cfg_we cfg_index cfg_data                           one register write
//
// a pixel with a full 3x3 window occupies the sequencer for one pass per filter,
// one filter pass issued per cycle while the chain advances; a weight write takes
// a single pass and other requests none; each pass then runs through the tap chain
// rst is synchronous; line buffer columns read as zero until written, no sweep
// a stalled result holds the tap chain; requests land in front until the feed fills
module conv3x3_multi_filter_relu_top #(
  parameter int MAX_WIDTH   = 32,
  parameter int NUM_FILTERS = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [c3mf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3mf_pkg::CFG_DATA_W-1:0]    cfg_data,
  c3mf_in_if.sink                            req,
  c3mf_out_if.source                         res
);

  localparam int TAPS   = c3mf_pkg::TAPS;
  localparam int ACC_W  = c3mf_pkg::ACC_W;
  localparam int VAL_W  = c3mf_pkg::VAL_W;
  localparam int FILT_W = c3mf_pkg::FILT_W;

  // configuration registers
  logic [c3mf_pkg::CFGW_W-1:0] cfg_w;
  logic [c3mf_pkg::CFGH_W-1:0] cfg_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= c3mf_pkg::WIDTH_RST;
      cfg_h <= c3mf_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (c3mf_pkg::cfg_reg_t'(cfg_index))
        c3mf_pkg::CFG_WIDTH:  cfg_w <= cfg_data[c3mf_pkg::CFGW_W-1:0];
        c3mf_pkg::CFG_HEIGHT: cfg_h <= cfg_data[c3mf_pkg::CFGH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // the chain moves whenever the output register is free or drains
  logic           adv;
  c3mf_pkg::tok_t chain [TAPS+1];

  assign adv = !res.valid || res.ready;

  c3mf_feed #(
    .MAX_WIDTH   (MAX_WIDTH),
    .NUM_FILTERS (NUM_FILTERS)
  ) u_feed (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cfg_w (cfg_w),
    .cfg_h (cfg_h),
    .adv   (adv),
    .tok   (chain[0])
  );

  // one cell per window tap, each adds its pixel times weight
  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    c3mf_cell #(
      .NUM_FILTERS (NUM_FILTERS),
      .TAP         (t)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (chain[t]),
      .tok_out (chain[t+1])
    );
  end

  // output register, relu on the finished sum; weight writes drop out here
  c3mf_pkg::tok_t              done;
  logic                        o_valid;
  logic [FILT_W-1:0]           o_channel;
  logic [c3mf_pkg::ROW_W-1:0]  o_row;
  logic [c3mf_pkg::COL_W-1:0]  o_col;
  logic [VAL_W-1:0]            o_value;
  logic                        o_last;

  assign done = chain[TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid   <= done.valid && !done.is_wr;
      o_channel <= FILT_W'(done.filt);
      o_row     <= done.row;
      o_col     <= done.col;
      o_value   <= done.psum[ACC_W-1] ? '0 : done.psum[VAL_W-1:0];
      o_last    <= done.last;
    end
  end

  assign res.valid   = o_valid;
  assign res.channel = o_channel;
  assign res.out_row = o_row;
  assign res.out_col = o_col;
  assign res.value   = o_value;
  assign res.last    = o_last;

endmodule

### src/c3mf_line.sv
// two-row line buffer memory, one word per column, valid bits for reset
module c3mf_line #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
  output logic [2*c3mf_pkg::PIX_W-1:0]        rd_word,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
  input  logic [2*c3mf_pkg::PIX_W-1:0]        wr_word
);

  localparam int WORD_W = 2 * c3mf_pkg::PIX_W;

  logic [WORD_W-1:0]    mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] vld;
  logic [WORD_W-1:0]    rd_raw;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // unwritten columns read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_word = rd_vld ? rd_raw : '0;

endmodule

### src/c3mf_cell.sv
// one tap cell: holds this tap's weight for every filter, multiply-adds
module c3mf_cell #(
  parameter int NUM_FILTERS = 5,
  parameter int TAP         = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  c3mf_pkg::tok_t  tok_in,
  output c3mf_pkg::tok_t  tok_out
);

  localparam int CNT_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int ACC_W = c3mf_pkg::ACC_W;
  localparam int PRD_W = c3mf_pkg::PIX_W + 1 + c3mf_pkg::WGT_W;

  logic signed [c3mf_pkg::WGT_W-1:0] wgt [NUM_FILTERS];
  logic signed [c3mf_pkg::WGT_W-1:0] wsel;
  logic signed [PRD_W-1:0]           prod;
  logic [CNT_W-1:0]                  fsel;
  logic                              wr_hit;
  c3mf_pkg::tok_t                    nxt;

  assign fsel   = tok_in.filt[CNT_W-1:0];
  assign wsel   = wgt[fsel];
  assign prod   = $signed({1'b0, tok_in.pix[TAP]}) * wsel;
  assign wr_hit = tok_in.valid && tok_in.is_wr &&
                  (tok_in.tap == c3mf_pkg::TAP_W'(TAP));

  always_comb begin
    nxt      = tok_in;
    nxt.psum = tok_in.psum + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (adv && wr_hit) begin
      wgt[fsel] <= tok_in.wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= nxt;
    end
  end

endmodule

### src/c3mf_feed.sv
// request front end: counters, line buffer, window and filter sequencer
module c3mf_feed #(
  parameter int MAX_WIDTH   = 32,
  parameter int NUM_FILTERS = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  c3mf_in_if.sink                          req,
  input  logic [c3mf_pkg::CFGW_W-1:0]      cfg_w,
  input  logic [c3mf_pkg::CFGH_W-1:0]      cfg_h,
  input  logic                             adv,
  output c3mf_pkg::tok_t                   tok
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CNT_W  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int PIX_W  = c3mf_pkg::PIX_W;
  localparam int ROW_W  = c3mf_pkg::ROW_W;
  localparam int COL_W  = c3mf_pkg::COL_W;
  localparam int FSEL_W = c3mf_pkg::FSEL_W;
  localparam int ACC_W  = c3mf_pkg::ACC_W;
  localparam int TAP_W  = c3mf_pkg::TAP_W;

  // position counters
  logic [ROW_W-1:0] r_cnt;
  logic [CW-1:0]    c_cnt;
  logic [CW-1:0]    last_col;
  logic [ROW_W-1:0] last_row;

  // request waiting for its line buffer read
  logic                              pend_valid;
  c3mf_pkg::req_type_t               pend_type;
  logic [PIX_W-1:0]                  pend_pix;
  logic [CW-1:0]                     pend_c;
  logic                              pend_full;
  logic [ROW_W-1:0]                  pend_orow;
  logic [COL_W-1:0]                  pend_ocol;
  logic [c3mf_pkg::FILT_W-1:0]       pend_filt;
  logic [TAP_W-1:0]                  pend_tap;
  logic signed [c3mf_pkg::WGT_W-1:0] pend_wval;
  logic signed [c3mf_pkg::BIAS_W-1:0] pend_bval;

  // window and sequencer
  logic [c3mf_pkg::TAPS-1:0][PIX_W-1:0] win;
  logic                                 busy;
  logic                                 s_wr;
  logic [CNT_W-1:0]                     cnt;
  logic [ROW_W-1:0]                     s_row;
  logic [COL_W-1:0]                     s_col;
  logic [TAP_W-1:0]                     s_tap;
  logic signed [c3mf_pkg::WGT_W-1:0]    s_wval;
  logic signed [c3mf_pkg::BIAS_W-1:0]   bias [NUM_FILTERS];

  logic [2*PIX_W-1:0] rd_word;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;
  logic               accept;
  logic               take;
  logic               last_issue;
  logic               seq_free;
  logic               filt_ok;
  logic               is_pix_in;
  logic               mem_wr;

  always_comb begin
    if (cfg_w < c3mf_pkg::CFGW_W'(3)) begin
      last_col = CW'(2);
    end else if (int'(cfg_w) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(cfg_w - c3mf_pkg::CFGW_W'(1));
    end
  end

  assign last_row = (cfg_h < ROW_W'(3)) ? ROW_W'(2) : (cfg_h - ROW_W'(1));

  assign last_issue = s_wr || (cnt == CNT_W'(NUM_FILTERS - 1));
  assign seq_free   = !busy || (adv && last_issue);
  assign take       = pend_valid && seq_free;
  assign req.ready  = !pend_valid || take;
  assign accept     = req.valid && req.ready;
  assign is_pix_in  = (req.req_type == c3mf_pkg::REQ_PIXEL);
  assign filt_ok    = (int'(pend_filt) < NUM_FILTERS);
  assign mem_wr     = take && (pend_type == c3mf_pkg::REQ_PIXEL);

  assign top = rd_word[2*PIX_W-1:PIX_W];
  assign mid = rd_word[PIX_W-1:0];

  c3mf_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && is_pix_in),
    .rd_addr (c_cnt),
    .rd_word (rd_word),
    .wr_en   (mem_wr),
    .wr_addr (pend_c),
    .wr_word ({mid, pend_pix})
  );

  // chain entry, bias seeds the partial sum
  always_comb begin
    tok.valid = busy;
    tok.is_wr = s_wr;
    tok.filt  = FSEL_W'(cnt);
    tok.tap   = s_tap;
    tok.wval  = s_wval;
    tok.pix   = win;
    tok.psum  = ACC_W'(bias[cnt]);
    tok.row   = s_row;
    tok.col   = s_col;
    tok.last  = !s_wr && (cnt == CNT_W'(NUM_FILTERS - 1));
  end

  always_ff @(posedge clk) begin
    if (take && (pend_type == c3mf_pkg::REQ_BIAS) && filt_ok) begin
      bias[CNT_W'(pend_filt)] <= pend_bval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt      <= '0;
      c_cnt      <= '0;
      pend_valid <= 1'b0;
      busy       <= 1'b0;
      s_wr       <= 1'b0;
      cnt        <= '0;
      win        <= '0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
        pend_type  <= c3mf_pkg::req_type_t'(req.req_type);
        pend_pix   <= req.pixel;
        pend_c     <= c_cnt;
        pend_full  <= (r_cnt >= ROW_W'(2)) && (c_cnt >= CW'(2));
        pend_orow  <= r_cnt - ROW_W'(2);
        pend_ocol  <= COL_W'(c_cnt - CW'(2));
        pend_filt  <= req.filter_index;
        pend_tap   <= req.tap_index;
        pend_wval  <= req.weight_value;
        pend_bval  <= req.bias_value;
        if (is_pix_in) begin
          if (c_cnt >= last_col) begin
            c_cnt <= '0;
            r_cnt <= (r_cnt >= last_row) ? '0 : (r_cnt + ROW_W'(1));
          end else begin
            c_cnt <= c_cnt + CW'(1);
          end
        end
      end else if (take) begin
        pend_valid <= 1'b0;
      end

      if (take) begin
        busy <= 1'b0;
        unique case (pend_type)
          c3mf_pkg::REQ_PIXEL: begin
            win[0] <= win[1];
            win[1] <= win[2];
            win[2] <= top;
            win[3] <= win[4];
            win[4] <= win[5];
            win[5] <= mid;
            win[6] <= win[7];
            win[7] <= win[8];
            win[8] <= pend_pix;
            if (pend_full) begin
              busy  <= 1'b1;
              s_wr  <= 1'b0;
              cnt   <= '0;
              s_row <= pend_orow;
              s_col <= pend_ocol;
            end
          end
          c3mf_pkg::REQ_WEIGHT: begin
            if (filt_ok && (pend_tap < TAP_W'(c3mf_pkg::TAPS))) begin
              busy   <= 1'b1;
              s_wr   <= 1'b1;
              cnt    <= CNT_W'(pend_filt);
              s_tap  <= pend_tap;
              s_wval <= pend_wval;
            end
          end
          default: begin
          end
        endcase
      end else if (busy && adv) begin
        if (last_issue) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

### tb/sv/conv3x3_multi_filter_relu_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming 3x3 multi-filter convolution with relu
module conv3x3_multi_filter_relu_top_test;

  localparam int MAX_WIDTH   = 32;
  localparam int NUM_FILTERS = 5;
  localparam int SETTLE      = 40;    // tap chain plus filter sequencing, with slack
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES = 300;   // long result hold-off, fills the tap chain

  localparam int TAPS       = c3mf_pkg::TAPS;
  localparam int REQ_W      = c3mf_pkg::REQ_W;
  localparam int PIX_W      = c3mf_pkg::PIX_W;
  localparam int FILT_W     = c3mf_pkg::FILT_W;
  localparam int TAP_W      = c3mf_pkg::TAP_W;
  localparam int WGT_W      = c3mf_pkg::WGT_W;
  localparam int BIAS_W     = c3mf_pkg::BIAS_W;
  localparam int ROW_W      = c3mf_pkg::ROW_W;
  localparam int COL_W      = c3mf_pkg::COL_W;
  localparam int VAL_W      = c3mf_pkg::VAL_W;
  localparam int CFGW_W     = c3mf_pkg::CFGW_W;
  localparam int CFGH_W     = c3mf_pkg::CFGH_W;
  localparam int CFG_DATA_W = c3mf_pkg::CFG_DATA_W;
  localparam int CFG_IDX_W  = c3mf_pkg::CFG_IDX_W;

  // request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  localparam logic signed [WGT_W-1:0]  WGT_MAX  = 16'sh7fff;
  localparam logic signed [WGT_W-1:0]  WGT_MIN  = 16'sh8000;
  localparam logic signed [BIAS_W-1:0] BIAS_MAX = 28'sh7ffffff;
  localparam logic signed [BIAS_W-1:0] BIAS_MIN = 28'sh8000000;

  typedef struct {
    logic [REQ_W-1:0]         kind;
    logic [PIX_W-1:0]         pixel;
    logic [FILT_W-1:0]        filt;
    logic [TAP_W-1:0]         tap;
    logic signed [WGT_W-1:0]  wgt;
    logic signed [BIAS_W-1:0] bias;
  } conv_req_t;

  typedef struct {
    logic [FILT_W-1:0] channel;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [VAL_W-1:0]  value;
    logic              last;
  } conv_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  c3mf_in_if  req_ch ();
  c3mf_out_if res_ch ();

  conv3x3_multi_filter_relu_top #(
    .MAX_WIDTH   (MAX_WIDTH),
    .NUM_FILTERS (NUM_FILTERS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predictor copy of the block state
  logic [PIX_W-1:0]         line_buf [2*MAX_WIDTH];
  logic [PIX_W-1:0]         win_pix [TAPS];
  logic signed [WGT_W-1:0]  wgt_mem [NUM_FILTERS*TAPS];
  logic signed [BIAS_W-1:0] bias_mem [NUM_FILTERS];
  int unsigned              row_pos;
  int unsigned              col_pos;
  logic [CFGW_W-1:0]        width_reg;
  logic [CFGH_W-1:0]        height_reg;

  conv_result_t pending_results [$];
  int           fail_count;
  bit           src_idle;    // random gaps on the request side
  bit           sink_idle;   // random stalls on the result side
  int           hold_left;   // long result hold-off, counted down by the sink

  // store a weight or bias, or shift a pixel through line buffers and window, queue outputs
  function automatic void predict_conv(input conv_req_t r);
    int unsigned      w, h, c, rr, ci;
    int               px;
    longint           acc, tw;
    logic [PIX_W-1:0] top, mid;
    conv_result_t     e;
    if (r.kind == c3mf_pkg::REQ_WEIGHT) begin
      if (r.filt < NUM_FILTERS && r.tap < TAPS) wgt_mem[r.filt * TAPS + r.tap] = r.wgt;
      return;
    end
    if (r.kind == c3mf_pkg::REQ_BIAS) begin
      if (r.filt < NUM_FILTERS) bias_mem[r.filt] = r.bias;
      return;
    end
    if (r.kind != c3mf_pkg::REQ_PIXEL) return;

    // registers outside their range act as the nearest legal size
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;

    c  = col_pos;
    rr = row_pos;
    ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    top = line_buf[ci];
    mid = line_buf[MAX_WIDTH + ci];
    line_buf[ci] = mid;
    line_buf[MAX_WIDTH + ci] = r.pixel;

    for (int k = 0; k < 3; k++) begin
      win_pix[k*3]   = win_pix[k*3+1];
      win_pix[k*3+1] = win_pix[k*3+2];
    end
    win_pix[2] = top;
    win_pix[5] = mid;
    win_pix[8] = r.pixel;

    if (rr >= 2 && c >= 2) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        acc = bias_mem[f];
        for (int t = 0; t < TAPS; t++) begin
          px  = win_pix[t];
          tw  = wgt_mem[f * TAPS + t];
          acc += px * tw;
        end
        e.channel = FILT_W'(f);
        e.out_row = ROW_W'(rr - 2);
        e.out_col = COL_W'(c - 2);
        e.value   = (acc < 0) ? '0 : acc[VAL_W-1:0];
        e.last    = (f == NUM_FILTERS - 1);
        pending_results.push_back(e);
      end
    end

    // a column or row at or past a shrunken limit ends the row or frame
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (rr >= h - 1) ? 0 : ((rr + 1) & 10'h3ff);
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic conv_req_t mk_req(input logic [REQ_W-1:0] kind, input int pixel,
                                       input int filt, input int tap,
                                       input logic signed [WGT_W-1:0] wgt,
                                       input logic signed [BIAS_W-1:0] bias);
    conv_req_t r;
    r.kind  = kind;
    r.pixel = PIX_W'(pixel);
    r.filt  = FILT_W'(filt);
    r.tap   = TAP_W'(tap);
    r.wgt   = wgt;
    r.bias  = bias;
    return r;
  endfunction

  // mostly pixels, some stores, a few ignored codes; every field fully random
  function automatic conv_req_t rand_req();
    conv_req_t r;
    int        sel;
    sel = $urandom_range(0, 99);
    if (sel < 84)      r.kind = c3mf_pkg::REQ_PIXEL;
    else if (sel < 92) r.kind = c3mf_pkg::REQ_WEIGHT;
    else if (sel < 97) r.kind = c3mf_pkg::REQ_BIAS;
    else               r.kind = REQ_NONE;
    r.pixel = PIX_W'($urandom);
    r.filt  = FILT_W'($urandom);
    r.tap   = TAP_W'($urandom);
    r.wgt   = WGT_W'($urandom);
    r.bias  = BIAS_W'($urandom);
    return r;
  endfunction

  // offer one request beat; entered and left just after a falling edge
  // valid stays high on return so back-to-back beats need no toggle
  task automatic send_req(input conv_req_t r);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.kind;
    req_ch.pixel        <= r.pixel;
    req_ch.filter_index <= r.filt;
    req_ch.tap_index    <= r.tap;
    req_ch.weight_value <= r.wgt;
    req_ch.bias_value   <= r.bias;
    do @(posedge clk); while (!req_ch.ready);
    predict_conv(r);
    @(negedge clk);
  endtask

  // stop offering, wait for every queued result, then let the tap chain settle
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // program both frame registers while the block is idle
  task automatic set_frame(input logic [CFGW_W-1:0] w, input logic [CFGH_W-1:0] h);
    logic [CFG_DATA_W-1:0] d;
    wait_drained();
    d = CFG_DATA_W'($urandom);  // upper bits above the width register are don't-care
    d[CFGW_W-1:0] = w;
    cfg_we    <= 1'b1;
    cfg_index <= c3mf_pkg::CFG_WIDTH;
    cfg_data  <= d;
    @(negedge clk);
    cfg_index <= c3mf_pkg::CFG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // every weight and bias is written before any window is formed
  task automatic test_filter_load();
    logic signed [WGT_W-1:0]  wv;
    logic signed [BIAS_W-1:0] bv;
    for (int f = 0; f < NUM_FILTERS; f++) begin
      for (int t = 0; t < TAPS; t++) begin
        if (f == 0)      wv = WGT_MAX;
        else if (f == 1) wv = WGT_MIN;
        else             wv = WGT_W'($urandom);
        send_req(mk_req(c3mf_pkg::REQ_WEIGHT, $urandom, f, t, wv, BIAS_W'($urandom)));
      end
    end
    for (int f = 0; f < NUM_FILTERS; f++) begin
      if (f == 0)      bv = BIAS_MAX;
      else if (f == 1) bv = BIAS_MIN;
      else if (f == 2) bv = '0;
      else             bv = BIAS_W'($urandom);
      send_req(mk_req(c3mf_pkg::REQ_BIAS, $urandom, f, $urandom, WGT_W'($urandom), bv));
    end
  endtask

  // smallest frame: full-scale pixels hit the largest sum and the clamp, zeros give bias only
  task automatic test_pixel_extremes();
    set_frame(6'd3, 10'd3);
    repeat (9) send_req(mk_req(c3mf_pkg::REQ_PIXEL, 255, $urandom, $urandom,
                               WGT_W'($urandom), BIAS_W'($urandom)));
    repeat (9) send_req(mk_req(c3mf_pkg::REQ_PIXEL, 0, $urandom, $urandom,
                               WGT_W'($urandom), BIAS_W'($urandom)));
  endtask

  // unused request code and out-of-range indexes must leave the stores alone
  task automatic test_ignored_requests();
    repeat (2) send_req(mk_req(REQ_NONE, $urandom, $urandom, $urandom,
                               WGT_W'($urandom), BIAS_W'($urandom)));
    send_req(mk_req(c3mf_pkg::REQ_WEIGHT, $urandom, 5, 0, WGT_MIN, BIAS_W'($urandom)));
    send_req(mk_req(c3mf_pkg::REQ_WEIGHT, $urandom, 0, 9, WGT_MIN, BIAS_W'($urandom)));
    send_req(mk_req(c3mf_pkg::REQ_WEIGHT, $urandom, 7, 15, '0, BIAS_W'($urandom)));
    send_req(mk_req(c3mf_pkg::REQ_BIAS, $urandom, 5, $urandom, WGT_W'($urandom), BIAS_MIN));
    send_req(mk_req(c3mf_pkg::REQ_BIAS, $urandom, 7, $urandom, WGT_W'($urandom), '0));
    repeat (9) send_req(mk_req(c3mf_pkg::REQ_PIXEL, $urandom, $urandom, $urandom,
                               WGT_W'($urandom), BIAS_W'($urandom)));
  endtask

  // walk through frame sizes, extremes and out-of-range codes among them; phases
  // stop mid-row so a shrunken width or height cuts a row or frame short
  task automatic test_frame_settings();
    logic [CFGW_W-1:0] ws [8] = '{6'd32, 6'd7, 6'd0, 6'd63, 6'd5, 6'd3, 6'd17, 6'd2};
    logic [CFGH_W-1:0] hs [8] = '{10'd1023, 10'd4, 10'd0, 10'd6, 10'd1023, 10'd2,
                                  10'd3, 10'd9};
    for (int p = 0; p < 8; p++) begin
      set_frame(ws[p], hs[p]);
      repeat ($urandom_range(10, 18)) send_req(rand_req());
    end
  endtask

  // results held off for a long stretch while pixels keep coming, so input stalls
  task automatic test_output_backpressure();
    conv_req_t r;
    set_frame(6'd6, 10'd12);
    hold_left = HOLD_CYCLES;
    repeat (45) begin
      r = rand_req();
      r.kind = c3mf_pkg::REQ_PIXEL;
      send_req(r);
    end
  endtask

  // sender goes quiet until everything owed has come back, then resumes
  task automatic test_sender_pause();
    repeat (20) send_req(rand_req());
    wait_drained();
    repeat (20) send_req(rand_req());
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    set_frame(6'd4, 10'd5);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (40) send_req(rand_req());
  endtask

  // result sink: ready changes at the falling edge only
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // each result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    conv_result_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display({"%0t: result with none expected, expected none actual",
                  " ch %0d row %0d col %0d val %0d"},
                 $time, res_ch.channel, res_ch.out_row, res_ch.out_col, res_ch.value);
      end else begin
        e = pending_results.pop_front();
        check_field("channel", e.channel, res_ch.channel);
        check_field("out_row", e.out_row, res_ch.out_row);
        check_field("out_col", e.out_col, res_ch.out_col);
        check_field("value",   e.value,   res_ch.value);
        check_field("last",    e.last,    res_ch.last);
      end
    end
  end

  // give up when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = c3mf_pkg::CFG_WIDTH;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = c3mf_pkg::REQ_PIXEL;
    req_ch.pixel        = '0;
    req_ch.filter_index = '0;
    req_ch.tap_index    = '0;
    req_ch.weight_value = '0;
    req_ch.bias_value   = '0;

    foreach (line_buf[i]) line_buf[i] = '0;
    foreach (win_pix[i]) win_pix[i] = '0;
    foreach (wgt_mem[i]) wgt_mem[i] = '0;
    foreach (bias_mem[i]) bias_mem[i] = '0;
    row_pos    = 0;
    col_pos    = 0;
    width_reg  = c3mf_pkg::WIDTH_RST;
    height_reg = c3mf_pkg::HEIGHT_RST;
    fail_count = 0;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    hold_left  = 0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_filter_load();
    test_pixel_extremes();
    test_ignored_requests();
    test_frame_settings();
    test_output_backpressure();
    test_sender_pause();
    test_steady_stream();

    // everything owed must arrive, then a quiet tail to catch strays
    wait_drained();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
src/c3mf_pkg.sv
src/c3mf_ifs.sv
src/c3mf_line.sv
src/c3mf_cell.sv
src/c3mf_feed.sv
src/conv3x3_multi_filter_relu_top.sv
tb/sv/conv3x3_multi_filter_relu_top_test.sv
